### hw/rtl/epoch_seconds_to_utc_date_unit_assert.svh
// Assertion macros for the epoch seconds to UTC date unit.
// Included by the modules that carry checks; needs nothing else.
`ifndef EPOCH_SECONDS_TO_UTC_DATE_UNIT_ASSERT_SVH
`define EPOCH_SECONDS_TO_UTC_DATE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define ESUD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// Next-cycle implication.
`define ESUD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ESUD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ESUD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

### hw/rtl/esud_pkg.sv
// Shared types, constants and tables for the epoch seconds to UTC date unit.
// Used by the microcode ROM, the sequencer, the datapath and the top level.
package esud_pkg;

   localparam int unsigned PC_W = 5;

   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [16:0] DAYS_PER_CYC  = 17'd1461;
   localparam logic [16:0] DAYS_PER_WEEK = 17'd7;
   localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [16:0] SECS_PER_MIN  = 17'd60;

   // Reciprocals scaled by 2^32; the quotient estimate is low by at most one.
   localparam logic [31:0] RECIP_DAY  = 32'(64'h1_0000_0000 / SECS_PER_DAY);
   localparam logic [31:0] RECIP_CYC  = 32'(64'h1_0000_0000 / DAYS_PER_CYC);
   localparam logic [31:0] RECIP_WEEK = 32'(64'h1_0000_0000 / DAYS_PER_WEEK);
   localparam logic [31:0] RECIP_HOUR = 32'(64'h1_0000_0000 / SECS_PER_HOUR);
   localparam logic [31:0] RECIP_MIN  = 32'(64'h1_0000_0000 / SECS_PER_MIN);

   localparam logic [7:0]  BASE_YEAR     = 8'd70;
   localparam logic [31:0] BASE_WEEKDAY  = 32'd4;
   localparam logic [10:0] DAYS_COMMON   = 11'd365;
   localparam logic [10:0] DAYS_LEAP     = 11'd366;
   localparam logic [3:0]  MONTHS        = 4'd12;

   localparam logic [PC_W-1:0] STEP_MSRCH = 5'd19;
   localparam logic [PC_W-1:0] STEP_EMIT  = 5'd21;

   typedef enum logic [3:0] {
      OP_JNEG  = 4'd0,
      OP_MULQ  = 4'd1,
      OP_MULR  = 4'd2,
      OP_FIX   = 4'd3,
      OP_YSUB  = 4'd4,
      OP_YLEAP = 4'd5,
      OP_MSRCH = 4'd6,
      OP_MDONE = 4'd7,
      OP_EMIT  = 4'd8
   } op_type;

   typedef enum logic [2:0] {
      DIV_DAY  = 3'd0,
      DIV_CYC  = 3'd1,
      DIV_WEEK = 3'd2,
      DIV_HOUR = 3'd3,
      DIV_MIN  = 3'd4
   } div_type;

   typedef enum logic [1:0] {
      SEQ_NEXT = 2'd0,
      SEQ_JUMP = 2'd1,
      SEQ_END  = 2'd2
   } seq_type;

   typedef struct packed {
      op_type          op;
      div_type         div;
      seq_type         seq;
      logic [PC_W-1:0] target;
   } uword_type;

   typedef struct packed {
      logic load;
      logic step_en;
   } dp_ctrl_type;

   localparam logic [8:0] START_COMMON [13] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
   };
   localparam logic [8:0] START_LEAP [13] = '{
      9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
      9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
   };

   function automatic uword_type make_uword(op_type op, div_type div, seq_type seq,
                                            logic [PC_W-1:0] target);
      uword_type w;
      w.op     = op;
      w.div    = div;
      w.seq    = seq;
      w.target = target;
      return w;
   endfunction

   // First day of year (zero-based) of a month; entry 12 is the year length.
   function automatic logic [8:0] month_start(logic leap, logic [3:0] idx);
      logic [8:0] v;
      v = 9'd0;
      if (idx <= MONTHS) begin
         v = leap ? START_LEAP[idx] : START_COMMON[idx];
      end
      return v;
   endfunction

   function automatic logic [16:0] div_const(div_type div);
      logic [16:0] d;
      unique case (div)
         DIV_DAY:  d = SECS_PER_DAY;
         DIV_CYC:  d = DAYS_PER_CYC;
         DIV_WEEK: d = DAYS_PER_WEEK;
         DIV_HOUR: d = SECS_PER_HOUR;
         DIV_MIN:  d = SECS_PER_MIN;
         default:  d = SECS_PER_MIN;
      endcase
      return d;
   endfunction

   function automatic logic [31:0] div_recip(div_type div);
      logic [31:0] m;
      unique case (div)
         DIV_DAY:  m = RECIP_DAY;
         DIV_CYC:  m = RECIP_CYC;
         DIV_WEEK: m = RECIP_WEEK;
         DIV_HOUR: m = RECIP_HOUR;
         DIV_MIN:  m = RECIP_MIN;
         default:  m = RECIP_MIN;
      endcase
      return m;
   endfunction

endpackage

### hw/rtl/esud_rom.sv
// Microcode ROM: one control word per program step.
// Depends on esud_pkg for the control word layout and step names.
module esud_rom (
   input  logic [esud_pkg::PC_W-1:0] pc,
   output esud_pkg::uword_type       uword
);

   always_comb begin
      unique case (pc)
         5'd0:  uword = esud_pkg::make_uword(esud_pkg::OP_JNEG, esud_pkg::DIV_DAY,
                                            esud_pkg::SEQ_JUMP, esud_pkg::STEP_EMIT);
         5'd1:  uword = esud_pkg::make_uword(esud_pkg::OP_MULQ, esud_pkg::DIV_DAY,
                                            esud_pkg::SEQ_NEXT, '0);
         5'd2:  uword = esud_pkg::make_uword(esud_pkg::OP_MULR, esud_pkg::DIV_DAY,
                                            esud_pkg::SEQ_NEXT, '0);
         5'd3:  uword = esud_pkg::make_uword(esud_pkg::OP_FIX, esud_pkg::DIV_DAY,
                                            esud_pkg::SEQ_NEXT, '0);
         5'd4:  uword = esud_pkg::make_uword(esud_pkg::OP_MULQ, esud_pkg::DIV_CYC,
                                            esud_pkg::SEQ_NEXT, '0);
         5'd5:  uword = esud_pkg::make_uword(esud_pkg::OP_MULR, esud_pkg::DIV_CYC,
                                            esud_pkg::SEQ_NEXT, '0);
         5'd6:  uword = esud_pkg::make_uword(esud_pkg::OP_FIX, esud_pkg::DIV_CYC,
                                            esud_pkg::SEQ_NEXT, '0);
         5'd7:  uword = esud_pkg::make_uword(esud_pkg::OP_MULQ, esud_pkg::DIV_WEEK,
                                            esud_pkg::SEQ_NEXT, '0);
         5'd8:  uword = esud_pkg::make_uword(esud_pkg::OP_MULR, esud_pkg::DIV_WEEK,
                                            esud_pkg::SEQ_NEXT, '0);
         5'd9:  uword = esud_pkg::make_uword(esud_pkg::OP_FIX, esud_pkg::DIV_WEEK,
                                            esud_pkg::SEQ_NEXT, '0);
         5'd10: uword = esud_pkg::make_uword(esud_pkg::OP_MULQ, esud_pkg::DIV_HOUR,
                                            esud_pkg::SEQ_NEXT, '0);
         5'd11: uword = esud_pkg::make_uword(esud_pkg::OP_MULR, esud_pkg::DIV_HOUR,
                                            esud_pkg::SEQ_NEXT, '0);
         5'd12: uword = esud_pkg::make_uword(esud_pkg::OP_FIX, esud_pkg::DIV_HOUR,
                                            esud_pkg::SEQ_NEXT, '0);
         5'd13: uword = esud_pkg::make_uword(esud_pkg::OP_MULQ, esud_pkg::DIV_MIN,
                                            esud_pkg::SEQ_NEXT, '0);
         5'd14: uword = esud_pkg::make_uword(esud_pkg::OP_MULR, esud_pkg::DIV_MIN,
                                            esud_pkg::SEQ_NEXT, '0);
         5'd15: uword = esud_pkg::make_uword(esud_pkg::OP_FIX, esud_pkg::DIV_MIN,
                                            esud_pkg::SEQ_NEXT, '0);
         5'd16: uword = esud_pkg::make_uword(esud_pkg::OP_YSUB, esud_pkg::DIV_DAY,
                                            esud_pkg::SEQ_JUMP, esud_pkg::STEP_MSRCH);
         5'd17: uword = esud_pkg::make_uword(esud_pkg::OP_YSUB, esud_pkg::DIV_DAY,
                                            esud_pkg::SEQ_JUMP, esud_pkg::STEP_MSRCH);
         5'd18: uword = esud_pkg::make_uword(esud_pkg::OP_YLEAP, esud_pkg::DIV_DAY,
                                            esud_pkg::SEQ_NEXT, '0);
         5'd19: uword = esud_pkg::make_uword(esud_pkg::OP_MSRCH, esud_pkg::DIV_DAY,
                                            esud_pkg::SEQ_JUMP, esud_pkg::STEP_MSRCH);
         5'd20: uword = esud_pkg::make_uword(esud_pkg::OP_MDONE, esud_pkg::DIV_DAY,
                                            esud_pkg::SEQ_NEXT, '0);
         5'd21: uword = esud_pkg::make_uword(esud_pkg::OP_EMIT, esud_pkg::DIV_DAY,
                                            esud_pkg::SEQ_END, '0);
         default: uword = esud_pkg::make_uword(esud_pkg::OP_EMIT, esud_pkg::DIV_DAY,
                                              esud_pkg::SEQ_END, '0);
      endcase
   end

endmodule

### hw/rtl/esud_seq.sv
// Sequencer: step counter, conditional jumps and the request/result handshake.
// Depends on esud_pkg and the assertion macro header.
`include "epoch_seconds_to_utc_date_unit_assert.svh"

module esud_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  esud_pkg::uword_type       uword,
   input  logic                      cond,
   output logic [esud_pkg::PC_W-1:0] pc,
   output esud_pkg::dp_ctrl_type     ctrl
);

   logic                      busy_ff, busy_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [esud_pkg::PC_W-1:0] pc_ff, pc_in;
   logic                      load;
   logic                      out_free;
   logic                      step_en;
   logic                      emit_fire;

   assign load      = req_tvalid && !busy_ff;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   // The final step waits until the result register can take a new result.
   assign step_en   = busy_ff && ((uword.seq != esud_pkg::SEQ_END) || out_free);
   assign emit_fire = step_en && (uword.seq == esud_pkg::SEQ_END);

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (load) begin
         pc_in   = '0;
         busy_in = 1'b1;
      end else if (step_en) begin
         unique case (uword.seq)
            esud_pkg::SEQ_NEXT: pc_in = pc_ff + 1'b1;
            esud_pkg::SEQ_JUMP: pc_in = cond ? uword.target : pc_ff + 1'b1;
            esud_pkg::SEQ_END:  busy_in = 1'b0;
            default:            busy_in = 1'b0;
         endcase
      end
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_tready) || emit_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         pc_ff        <= pc_in;
      end
   end

   assign req_tready   = !busy_ff;
   assign rsp_tvalid   = rsp_valid_ff;
   assign pc           = pc_ff;
   assign ctrl.load    = load;
   assign ctrl.step_en = step_en;

   `ESUD_ASSERT_NXT(a_load_starts, clock, reset, load, busy_ff && (pc_ff == '0))
   `ESUD_ASSERT_NXT(a_emit_ends, clock, reset, emit_fire, rsp_valid_ff && !busy_ff)
   `ESUD_ASSERT_IMP(a_pc_in_program, clock, reset, busy_ff, pc_ff <= esud_pkg::STEP_EMIT)

endmodule

### hw/rtl/esud_dpath.sv
// Datapath: shared 32x32 multiplier for the constant divisions, year and month
// stepping, and the result register. Depends on esud_pkg and the macro header.
`include "epoch_seconds_to_utc_date_unit_assert.svh"

module esud_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [31:0]           req_tdata,
   input  esud_pkg::uword_type   uword,
   input  esud_pkg::dp_ctrl_type ctrl,
   output logic                  cond,
   output logic [47:0]           rsp_tdata,
   output logic                  rsp_tuser
);

   logic [31:0] x_ff, q_ff, r_ff;
   logic        neg_ff;
   logic [14:0] days_ff;
   logic [16:0] sod_ff;
   logic [7:0]  year_ff;
   logic [10:0] dic_ff;
   logic        leap_ff;
   logic [3:0]  mon_ff;
   logic [4:0]  mday_ff;
   logic [2:0]  wday_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  min_ff;
   logic [5:0]  sec_ff;
   logic [47:0] rsp_tdata_ff;
   logic        rsp_tuser_ff;

   logic [16:0] dconst;
   logic [31:0] dconst32;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic        fix_ge;
   logic [31:0] q_fix, r_fix;
   logic [3:0]  mon_m1;
   logic [8:0]  start_cur, start_prev;
   logic        msrch_go;

   assign dconst   = esud_pkg::div_const(uword.div);
   assign dconst32 = 32'(dconst);

   // Pass one estimates the quotient, pass two forms the remainder.
   assign mul_a = (uword.op == esud_pkg::OP_MULR) ? q_ff : x_ff;
   assign mul_b = (uword.op == esud_pkg::OP_MULR) ? dconst32 : esud_pkg::div_recip(uword.div);
   assign prod  = 64'(mul_a) * 64'(mul_b);

   assign fix_ge = r_ff >= dconst32;
   assign q_fix  = fix_ge ? q_ff + 32'd1 : q_ff;
   assign r_fix  = fix_ge ? r_ff - dconst32 : r_ff;

   assign mon_m1     = mon_ff - 4'd1;
   assign start_cur  = esud_pkg::month_start(leap_ff, mon_ff);
   assign start_prev = esud_pkg::month_start(leap_ff, mon_m1);
   assign msrch_go   = (mon_ff < esud_pkg::MONTHS) && (11'(start_cur) <= dic_ff);

   always_comb begin
      unique case (uword.op)
         esud_pkg::OP_JNEG:  cond = neg_ff;
         esud_pkg::OP_YSUB:  cond = dic_ff < esud_pkg::DAYS_COMMON;
         esud_pkg::OP_MSRCH: cond = msrch_go;
         default:            cond = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         x_ff   <= req_tdata;
         neg_ff <= req_tdata[31];
      end else if (ctrl.step_en) begin
         unique case (uword.op)
            esud_pkg::OP_MULQ: q_ff <= prod[63:32];
            esud_pkg::OP_MULR: r_ff <= x_ff - prod[31:0];
            esud_pkg::OP_FIX: begin
               unique case (uword.div)
                  esud_pkg::DIV_DAY: begin
                     days_ff <= q_fix[14:0];
                     sod_ff  <= r_fix[16:0];
                     x_ff    <= q_fix;
                  end
                  esud_pkg::DIV_CYC: begin
                     year_ff <= {q_fix[5:0], 2'b00} + esud_pkg::BASE_YEAR;
                     dic_ff  <= r_fix[10:0];
                     leap_ff <= 1'b0;
                     mon_ff  <= 4'd1;
                     x_ff    <= 32'(days_ff) + esud_pkg::BASE_WEEKDAY;
                  end
                  esud_pkg::DIV_WEEK: begin
                     wday_ff <= r_fix[2:0];
                     x_ff    <= 32'(sod_ff);
                  end
                  esud_pkg::DIV_HOUR: begin
                     hour_ff <= q_fix[4:0];
                     x_ff    <= r_fix;
                  end
                  esud_pkg::DIV_MIN: begin
                     min_ff <= q_fix[5:0];
                     sec_ff <= r_fix[5:0];
                  end
                  default: ;
               endcase
            end
            esud_pkg::OP_YSUB: begin
               if (dic_ff >= esud_pkg::DAYS_COMMON) begin
                  dic_ff  <= dic_ff - esud_pkg::DAYS_COMMON;
                  year_ff <= year_ff + 8'd1;
               end
            end
            esud_pkg::OP_YLEAP: begin
               // Third year of the cycle is the leap year.
               if (dic_ff >= esud_pkg::DAYS_LEAP) begin
                  dic_ff  <= dic_ff - esud_pkg::DAYS_LEAP;
                  year_ff <= year_ff + 8'd1;
               end else begin
                  leap_ff <= 1'b1;
               end
            end
            esud_pkg::OP_MSRCH: begin
               if (msrch_go) begin
                  mon_ff <= mon_ff + 4'd1;
               end
            end
            esud_pkg::OP_MDONE: begin
               mon_ff  <= mon_m1;
               mday_ff <= 5'(dic_ff[8:0] - start_prev + 9'd1);
            end
            esud_pkg::OP_EMIT: begin
               if (neg_ff) begin
                  rsp_tdata_ff <= '0;
               end else begin
                  rsp_tdata_ff <= {2'b00, sec_ff, min_ff, hour_ff, wday_ff, dic_ff[8:0],
                                   mday_ff, mon_ff, year_ff};
               end
               rsp_tuser_ff <= !neg_ff;
            end
            default: ;
         endcase
      end
   end

   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;

   `ESUD_ASSERT_IMP(a_fix_one_step, clock, reset, ctrl.step_en && (uword.op == esud_pkg::OP_FIX), r_ff < (dconst32 + dconst32))
   `ESUD_ASSERT_IMP(a_msrch_month, clock, reset, ctrl.step_en && (uword.op == esud_pkg::OP_MSRCH), (mon_ff != 4'd0) && (mon_ff <= esud_pkg::MONTHS))
   `ESUD_ASSERT_NXT(a_emit_year, clock, reset, ctrl.step_en && (uword.op == esud_pkg::OP_EMIT) && !neg_ff, rsp_tuser_ff && (rsp_tdata_ff[7:0] >= esud_pkg::BASE_YEAR))

endmodule

### hw/rtl/epoch_seconds_to_utc_date_unit.sv
// Converts a signed 32-bit count of seconds since 1970-01-01 00:00 UTC into
// broken-down UTC calendar time. A small microcoded sequencer steps a datapath
// built around one shared 32x32 multiplier: each constant division (by seconds
// per day, days per four-year cycle, seven, 3600 and 60) is done as a
// reciprocal multiply, a remainder and one correction, then the year is settled
// in up to three steps and the month is found by a search that checks one table
// entry per cycle. How long a non-negative request runs depends on the year
// steps and the month search; a negative request goes straight to the result
// step and yields valid_res = 0 with all fields zero. One request is worked on
// at a time; a finished result waits in its own register, so the next request
// is accepted while it is still unread.
module epoch_seconds_to_utc_date_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] epoch_seconds
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] years_since_1900, [11:8] month_index, [16:12] day_of_month,
   // [25:17] day_of_year, [28:26] weekday, [33:29] hour_of_day,
   // [39:34] minute_of_hour, [45:40] second_of_minute, [47:46] zero
   output logic [47:0] rsp_tdata,
   output logic        rsp_tuser    // [0] valid_res
);

   logic [esud_pkg::PC_W-1:0] pc;
   esud_pkg::uword_type       uword;
   esud_pkg::dp_ctrl_type     ctrl;
   logic                      cond;

   esud_rom u_rom (
      .pc    (pc),
      .uword (uword)
   );

   esud_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .uword      (uword),
      .cond       (cond),
      .pc         (pc),
      .ctrl       (ctrl)
   );

   esud_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .uword     (uword),
      .ctrl      (ctrl),
      .cond      (cond),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

### tb/tb.sv
// Self-checking bench for epoch_seconds_to_utc_date_unit: random and corner-case
// requests, with an in-bench calendar predictor and an in-order scoreboard.
// Depends only on the RTL of the unit; no package items are needed at its ports.
module tb;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned PHASE_ITEMS  = 150;

   localparam logic [31:0] SECS_DAY   = 32'd86400;
   localparam logic [31:0] SECS_YEAR  = 32'd365 * 32'd86400;
   localparam logic [31:0] SECS_CYCLE = 32'd1461 * 32'd86400;

   typedef struct packed {
      logic       valid_res;
      logic [7:0] years_since_1900;
      logic [3:0] month_index;
      logic [4:0] day_of_month;
      logic [8:0] day_of_year;
      logic [2:0] weekday;
      logic [4:0] hour_of_day;
      logic [5:0] minute_of_hour;
      logic [5:0] second_of_minute;
   } utc_date_type;

   class date_scoreboard;
      utc_date_type pending_dates[$];
      int unsigned failures;

      // First zero-based day of each month; entry 12 is the year length.
      static function int unsigned month_first_day(bit leap, int unsigned month);
         int unsigned common_days [13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243,
                                           273, 304, 334, 365};
         int unsigned leap_days [13]   = '{0, 31, 60, 91, 121, 152, 182, 213, 244,
                                           274, 305, 335, 366};
         return leap ? leap_days[month] : common_days[month];
      endfunction

      static function utc_date_type convert_epoch(logic [31:0] secs);
         utc_date_type d;
         logic [31:0]  rest;
         int unsigned  year, yday, month;
         bit           leap;
         d = '0;
         if (!secs[31]) begin
            rest = secs % SECS_CYCLE;
            year = (secs / SECS_CYCLE) * 4 + 70;
            leap = 1'b0;
            // Within a four-year cycle the third year is the leap year.
            if (rest >= SECS_YEAR) begin
               year++;
               rest -= SECS_YEAR;
               if (rest >= SECS_YEAR) begin
                  year++;
                  rest -= SECS_YEAR;
                  if (rest >= SECS_YEAR + SECS_DAY) begin
                     year++;
                     rest -= SECS_YEAR + SECS_DAY;
                  end else begin
                     leap = 1'b1;
                  end
               end
            end
            yday = rest / SECS_DAY;
            rest = rest % SECS_DAY;
            month = 0;
            while (month < 11 && month_first_day(leap, month + 1) <= yday) begin
               month++;
            end
            d.valid_res        = 1'b1;
            d.years_since_1900 = 8'(year);
            d.month_index      = 4'(month);
            d.day_of_month     = 5'(yday - month_first_day(leap, month) + 1);
            d.day_of_year      = 9'(yday);
            d.weekday          = 3'((secs / SECS_DAY + 4) % 7);
            d.hour_of_day      = 5'(rest / 3600);
            d.minute_of_hour   = 6'((rest % 3600) / 60);
            d.second_of_minute = 6'(rest % 60);
         end
         return d;
      endfunction

      function void note_request(logic [31:0] secs);
         pending_dates.push_back(convert_epoch(secs));
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(logic [47:0] data, logic flag);
         utc_date_type want;
         if (pending_dates.size() == 0) begin
            $error("result with no request outstanding: tdata %h tuser %b", data, flag);
            failures++;
            return;
         end
         want = pending_dates.pop_front();
         compare_field("valid_res", want.valid_res, flag);
         compare_field("years_since_1900", want.years_since_1900, data[7:0]);
         compare_field("month_index", want.month_index, data[11:8]);
         compare_field("day_of_month", want.day_of_month, data[16:12]);
         compare_field("day_of_year", want.day_of_year, data[25:17]);
         compare_field("weekday", want.weekday, data[28:26]);
         compare_field("hour_of_day", want.hour_of_day, data[33:29]);
         compare_field("minute_of_hour", want.minute_of_hour, data[39:34]);
         compare_field("second_of_minute", want.second_of_minute, data[45:40]);
      endfunction

      function int unsigned outstanding();
         return pending_dates.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;

   int unsigned    send_idle_pct;
   int unsigned    recv_idle_pct;
   int unsigned    cycle_count;
   date_scoreboard date_board;

   epoch_seconds_to_utc_date_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         date_board.check_result(rsp_tdata, rsp_tuser);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(logic [31:0] secs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= secs;
      do begin
         @(posedge clock);
      end while (!req_tready);
      date_board.note_request(secs);
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (date_board.outstanding() != 0) begin
         @(negedge clock);
      end
   endtask

   // Mix of negative counts, uniform positive counts and whole-day counts plus a
   // time of day that lands on or next to a midnight or falls at random within the day.
   function automatic logic [31:0] random_epoch();
      int unsigned     pick;
      longint unsigned total;
      logic [31:0]     secs;
      pick = $urandom_range(99);
      if (pick < 15) begin
         secs = $urandom() | 32'h8000_0000;
      end else if (pick < 45) begin
         secs = $urandom() & 32'h7FFF_FFFF;
      end else begin
         total = longint'($urandom_range(24855)) * 86400;
         case ($urandom_range(2))
            0: total += 0;
            1: total += 86399;
            default: total += $urandom_range(86399);
         endcase
         if (total > 64'h7FFF_FFFF) begin
            total = 64'h7FFF_FFFF;
         end
         secs = 32'(total);
      end
      return secs;
   endfunction

   initial begin
      logic [31:0] corner_cases [$] = '{
         32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
         32'd31535999, 32'd31536000, 32'd36633599, 32'd36633600,
         32'd68169600, 32'd68256000, 32'd94608000, 32'd94694399, 32'd94694400,
         32'd126230399, 32'd126230400, 32'd946684800, 32'd951782400,
         32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hA5A5_5A5A
      };
      int unsigned send_pcts [3] = '{25, 69, 0};
      int unsigned recv_pcts [3] = '{69, 25, 0};

      date_board    = new();
      clock         = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      cycle_count   = 0;
      send_idle_pct = send_pcts[0];
      recv_idle_pct = recv_pcts[0];
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (corner_cases[i]) begin
         send_request(corner_cases[i]);
      end
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = send_pcts[phase];
         recv_idle_pct = recv_pcts[phase];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_request(random_epoch());
         end
         // Let the unit run dry before the idle pattern changes.
         wait_for_results();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (date_board.failures == 0 && date_board.outstanding() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### epoch_seconds_to_utc_date_unit.f
+incdir+hw/rtl
hw/rtl/esud_pkg.sv
hw/rtl/esud_rom.sv
hw/rtl/esud_seq.sv
hw/rtl/esud_dpath.sv
hw/rtl/epoch_seconds_to_utc_date_unit.sv
tb/tb.sv
